@@ rtl/assert_macros.svh @@
// Assertion macros shared by the remote command decoder RTL.
// Each macro expects clk_i and rst_ni to be in scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define RRCD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/rrcd_pkg.sv @@
// Package for the remote command decoder: types, command codes and limits.
// Used by rrcd_cfg, rrcd_state and robot_remote_command_decoder.
`timescale 1ns / 1ps
`default_nettype none

package rrcd_pkg;

  // ASCII characters used as group and code bytes.
  localparam logic [7:0] CHAR_0 = 8'd48;
  localparam logic [7:0] CHAR_1 = 8'd49;
  localparam logic [7:0] CHAR_2 = 8'd50;
  localparam logic [7:0] CHAR_3 = 8'd51;
  localparam logic [7:0] CHAR_4 = 8'd52;
  localparam logic [7:0] CHAR_5 = 8'd53;
  localparam logic [7:0] CHAR_6 = 8'd54;
  localparam logic [7:0] CHAR_7 = 8'd55;
  localparam logic [7:0] CHAR_8 = 8'd56;
  localparam logic [7:0] CHAR_9 = 8'd57;

  // Head angle limits and centre, in degrees.
  localparam logic [8:0] ANGLE_MAX    = 9'd180;
  localparam logic [7:0] ANGLE_STEP   = 8'd5;
  localparam logic [7:0] ANGLE_CENTRE = 8'd90;

  // Gait parameter limits and steps.
  localparam logic [6:0] LEN_MAX     = 7'd55;
  localparam logic [5:0] LEN_MIN_DN  = 6'd25;
  localparam logic [5:0] LEN_STEP    = 6'd5;
  localparam logic [7:0] PER_MAX     = 8'd70;
  localparam logic [6:0] PER_MIN_DN  = 7'd26;
  localparam logic [5:0] HGT_MAX     = 6'd28;
  localparam logic [4:0] HGT_MIN_DN  = 5'd14;
  localparam logic [4:0] HGT_STEP    = 5'd2;

  // Register reset values.
  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [5:0]  LEN_RST     = 6'd40;
  localparam logic [6:0]  PER_RST     = 7'd40;
  localparam logic [4:0]  HGT_RST     = 5'd20;

  // Item kinds and sources.
  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_CMD      = 1'b1;
  localparam logic SRC_WIRELESS  = 1'b0;

  typedef enum logic [1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_LEN_INIT = 2'd1,
    REG_PER_INIT = 2'd2,
    REG_HGT_INIT = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    MOT_STATIC = 4'd0,
    MOT_STEP   = 4'd1,
    MOT_FWD    = 4'd2,
    MOT_BACK   = 4'd3,
    MOT_LEFT   = 4'd4,
    MOT_RIGHT  = 4'd5,
    MOT_TURN_L = 4'd6,
    MOT_TURN_R = 4'd7,
    MOT_IMU    = 4'd8
  } motion_e;

  typedef enum logic [1:0] {
    GAIT_STAND = 2'd0,
    GAIT_WALK  = 2'd1,
    GAIT_TROT  = 2'd2,
    GAIT_TWIST = 2'd3
  } gait_e;

  typedef enum logic [1:0] {
    HEAD_NONE  = 2'd0,
    HEAD_NOD   = 2'd1,
    HEAD_SHAKE = 2'd2,
    HEAD_TILT  = 2'd3
  } head_e;

  // One input item.
  typedef struct packed {
    logic       kind;
    logic       source;
    logic [7:0] group_char;
    logic [7:0] code_char;
  } item_t;

  // Decoded state, ordered so that the last field sits in the lowest bits.
  typedef struct packed {
    logic       link_up;
    logic       trot_flag;
    logic [4:0] step_height;
    logic [6:0] step_period;
    logic [5:0] step_length;
    head_e      head_motion;
    logic [7:0] roll_deg;
    logic [7:0] pitch_deg;
    logic [7:0] yaw_deg;
    gait_e      gait;
    motion_e    motion_state;
  } result_t;

  // Configuration values and the load strobes for the working parameters.
  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic        len_load;
    logic        per_load;
    logic        hgt_load;
    logic [5:0]  len_init;
    logic [6:0]  per_init;
    logic [4:0]  hgt_init;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/rrcd_cfg.sv @@
// Configuration register file behind the APB-style port.
// Depends on rrcd_pkg for the register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module rrcd_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rrcd_pkg::cfg_t    cfg_o
);

  logic                wr_en;
  rrcd_pkg::reg_idx_e  idx;
  logic [15:0]         timeout_q, timeout_d;
  logic [5:0]          len_init_q, len_init_d;
  logic [6:0]          per_init_q, per_init_d;
  logic [4:0]          hgt_init_q, hgt_init_d;
  logic                len_load, per_load, hgt_load;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = rrcd_pkg::reg_idx_e'(paddr[3:2]);

  // Write decode.
  always_comb begin
    timeout_d  = timeout_q;
    len_init_d = len_init_q;
    per_init_d = per_init_q;
    hgt_init_d = hgt_init_q;
    len_load   = 1'b0;
    per_load   = 1'b0;
    hgt_load   = 1'b0;
    if (wr_en) begin
      unique case (idx)
        rrcd_pkg::REG_TIMEOUT:  timeout_d = pwdata[15:0];
        rrcd_pkg::REG_LEN_INIT: begin
          len_init_d = pwdata[5:0];
          len_load   = 1'b1;
        end
        rrcd_pkg::REG_PER_INIT: begin
          per_init_d = pwdata[6:0];
          per_load   = 1'b1;
        end
        rrcd_pkg::REG_HGT_INIT: begin
          hgt_init_d = pwdata[4:0];
          hgt_load   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // The working parameters load straight from the write data.
  assign cfg_o.timeout_ticks = timeout_q;
  assign cfg_o.len_load      = len_load;
  assign cfg_o.per_load      = per_load;
  assign cfg_o.hgt_load      = hgt_load;
  assign cfg_o.len_init      = pwdata[5:0];
  assign cfg_o.per_init      = pwdata[6:0];
  assign cfg_o.hgt_init      = pwdata[4:0];

  // Register storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= rrcd_pkg::TIMEOUT_RST;
      len_init_q <= rrcd_pkg::LEN_RST;
      per_init_q <= rrcd_pkg::PER_RST;
      hgt_init_q <= rrcd_pkg::HGT_RST;
    end else begin
      timeout_q  <= timeout_d;
      len_init_q <= len_init_d;
      per_init_q <= per_init_d;
      hgt_init_q <= hgt_init_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      rrcd_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_q};
      rrcd_pkg::REG_LEN_INIT: prdata = {26'd0, len_init_q};
      rrcd_pkg::REG_PER_INIT: prdata = {25'd0, per_init_q};
      rrcd_pkg::REG_HGT_INIT: prdata = {27'd0, hgt_init_q};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rrcd_state.sv @@
// Decoded robot state and the command decode that updates it per item.
// Depends on rrcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rrcd_state (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire rrcd_pkg::item_t  item_i,
  input  wire rrcd_pkg::cfg_t   cfg_i,
  output rrcd_pkg::result_t     result_o
);

  rrcd_pkg::result_t st_q, st_d;
  logic [15:0]       idle_q, idle_d, idle_inc;

  // Step conditions for the gait parameters and head angles.
  logic len_up_ok, len_dn_ok, per_up_ok, per_dn_ok, hgt_up_ok, hgt_dn_ok;
  logic yaw_up_ok, yaw_dn_ok, pit_up_ok, pit_dn_ok, rol_up_ok, rol_dn_ok;
  logic angles_ok;
  logic trot_gait;

  assign len_up_ok = ({1'b0, st_q.step_length} + 7'd5) <= rrcd_pkg::LEN_MAX;
  assign len_dn_ok = st_q.step_length >= rrcd_pkg::LEN_MIN_DN;
  assign per_up_ok = ({1'b0, st_q.step_period} + 8'd1) <= rrcd_pkg::PER_MAX;
  assign per_dn_ok = st_q.step_period >= rrcd_pkg::PER_MIN_DN;
  assign hgt_up_ok = ({1'b0, st_q.step_height} + 6'd2) <= rrcd_pkg::HGT_MAX;
  assign hgt_dn_ok = st_q.step_height >= rrcd_pkg::HGT_MIN_DN;
  assign yaw_up_ok = ({1'b0, st_q.yaw_deg} + 9'd5) <= rrcd_pkg::ANGLE_MAX;
  assign yaw_dn_ok = st_q.yaw_deg >= rrcd_pkg::ANGLE_STEP;
  assign pit_up_ok = ({1'b0, st_q.pitch_deg} + 9'd5) <= rrcd_pkg::ANGLE_MAX;
  assign pit_dn_ok = st_q.pitch_deg >= rrcd_pkg::ANGLE_STEP;
  assign rol_up_ok = ({1'b0, st_q.roll_deg} + 9'd5) <= rrcd_pkg::ANGLE_MAX;
  assign rol_dn_ok = st_q.roll_deg >= rrcd_pkg::ANGLE_STEP;

  // Saturating tick count.
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  // Decode of one item into the next state.
  always_comb begin
    st_d   = st_q;
    idle_d = idle_q;
    if (advance_i) begin
      if (item_i.kind == rrcd_pkg::KIND_CMD) begin
        unique case (item_i.group_char)
          rrcd_pkg::CHAR_0: begin
            unique case (item_i.code_char)
              rrcd_pkg::CHAR_5: st_d.motion_state = rrcd_pkg::MOT_STEP;
              rrcd_pkg::CHAR_2: st_d.motion_state = rrcd_pkg::MOT_FWD;
              rrcd_pkg::CHAR_8: st_d.motion_state = rrcd_pkg::MOT_BACK;
              rrcd_pkg::CHAR_4: st_d.motion_state = rrcd_pkg::MOT_LEFT;
              rrcd_pkg::CHAR_6: st_d.motion_state = rrcd_pkg::MOT_RIGHT;
              rrcd_pkg::CHAR_1: st_d.motion_state = rrcd_pkg::MOT_TURN_L;
              rrcd_pkg::CHAR_3: st_d.motion_state = rrcd_pkg::MOT_TURN_R;
              rrcd_pkg::CHAR_7: begin
                if (st_q.gait == rrcd_pkg::GAIT_TROT) begin
                  st_d.trot_flag = 1'b1;
                end else if (st_q.gait == rrcd_pkg::GAIT_TWIST) begin
                  st_d.motion_state = rrcd_pkg::MOT_IMU;
                end
              end
              default: ;
            endcase
          end
          rrcd_pkg::CHAR_1: begin
            st_d.trot_flag    = 1'b0;
            st_d.motion_state = rrcd_pkg::MOT_STATIC;
            unique case (item_i.code_char)
              rrcd_pkg::CHAR_0: st_d.gait = rrcd_pkg::GAIT_WALK;
              rrcd_pkg::CHAR_1: st_d.gait = rrcd_pkg::GAIT_TROT;
              rrcd_pkg::CHAR_3: st_d.gait = rrcd_pkg::GAIT_TWIST;
              default:          st_d.gait = rrcd_pkg::GAIT_STAND;
            endcase
          end
          rrcd_pkg::CHAR_2: begin
            unique case (item_i.code_char)
              rrcd_pkg::CHAR_1: if (len_up_ok) st_d.step_length = st_q.step_length + 6'd5;
              rrcd_pkg::CHAR_2: if (len_dn_ok) st_d.step_length = st_q.step_length - 6'd5;
              rrcd_pkg::CHAR_3: if (per_up_ok) st_d.step_period = st_q.step_period + 7'd1;
              rrcd_pkg::CHAR_4: if (per_dn_ok) st_d.step_period = st_q.step_period - 7'd1;
              rrcd_pkg::CHAR_5: if (hgt_up_ok) st_d.step_height = st_q.step_height + 5'd2;
              rrcd_pkg::CHAR_6: if (hgt_dn_ok) st_d.step_height = st_q.step_height - 5'd2;
              default: ;
            endcase
          end
          rrcd_pkg::CHAR_3: begin
            unique case (item_i.code_char)
              rrcd_pkg::CHAR_1: begin
                if (yaw_up_ok) st_d.yaw_deg = st_q.yaw_deg + 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_2: begin
                if (yaw_dn_ok) st_d.yaw_deg = st_q.yaw_deg - 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_3: begin
                if (pit_up_ok) st_d.pitch_deg = st_q.pitch_deg + 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_4: begin
                if (pit_dn_ok) st_d.pitch_deg = st_q.pitch_deg - 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_5: begin
                if (rol_up_ok) st_d.roll_deg = st_q.roll_deg + 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_6: begin
                if (rol_dn_ok) st_d.roll_deg = st_q.roll_deg - 8'd5;
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
              end
              rrcd_pkg::CHAR_7: st_d.head_motion = rrcd_pkg::HEAD_NOD;
              rrcd_pkg::CHAR_8: st_d.head_motion = rrcd_pkg::HEAD_SHAKE;
              rrcd_pkg::CHAR_9: st_d.head_motion = rrcd_pkg::HEAD_TILT;
              rrcd_pkg::CHAR_0: begin
                st_d.head_motion = rrcd_pkg::HEAD_NONE;
                st_d.yaw_deg     = rrcd_pkg::ANGLE_CENTRE;
                st_d.pitch_deg   = rrcd_pkg::ANGLE_CENTRE;
                st_d.roll_deg    = rrcd_pkg::ANGLE_CENTRE;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        // A wireless command refreshes the link after the decode.
        if (item_i.source == rrcd_pkg::SRC_WIRELESS) begin
          idle_d       = 16'd0;
          st_d.link_up = 1'b1;
        end
      end else begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.timeout_ticks) begin
          st_d.link_up = 1'b0;
        end
      end
    end
    // Init register writes reload the working parameters.
    if (cfg_i.len_load) st_d.step_length = cfg_i.len_init;
    if (cfg_i.per_load) st_d.step_period = cfg_i.per_init;
    if (cfg_i.hgt_load) st_d.step_height = cfg_i.hgt_init;
  end

  assign result_o = st_d;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.motion_state <= rrcd_pkg::MOT_STATIC;
      st_q.gait         <= rrcd_pkg::GAIT_STAND;
      st_q.yaw_deg      <= rrcd_pkg::ANGLE_CENTRE;
      st_q.pitch_deg    <= rrcd_pkg::ANGLE_CENTRE;
      st_q.roll_deg     <= rrcd_pkg::ANGLE_CENTRE;
      st_q.head_motion  <= rrcd_pkg::HEAD_NONE;
      st_q.step_length  <= rrcd_pkg::LEN_RST;
      st_q.step_period  <= rrcd_pkg::PER_RST;
      st_q.step_height  <= rrcd_pkg::HGT_RST;
      st_q.trot_flag    <= 1'b0;
      st_q.link_up      <= 1'b0;
      idle_q            <= 16'd0;
    end else begin
      st_q   <= st_d;
      idle_q <= idle_d;
    end
  end

  // Terms used by the checks below.
  assign angles_ok = ({1'b0, st_q.yaw_deg} <= rrcd_pkg::ANGLE_MAX) &&
                     ({1'b0, st_q.pitch_deg} <= rrcd_pkg::ANGLE_MAX) &&
                     ({1'b0, st_q.roll_deg} <= rrcd_pkg::ANGLE_MAX);
  assign trot_gait = (st_q.gait == rrcd_pkg::GAIT_TROT);

  // Angles start at the centre and only step inside their range.
  `RRCD_ASSERT(a_angles_in_range, angles_ok, "head angle out of range")
  // The trot flag is only ever raised while trotting.
  `RRCD_ASSERT(a_trot_in_trot, $rose(st_q.trot_flag) |-> trot_gait, "trot flag outside trot gait")
  // The link comes up only together with a cleared tick count.
  `RRCD_ASSERT(a_link_clears_idle, $rose(st_q.link_up) |-> idle_q == 16'd0, "link up, stale count")

endmodule

`default_nettype wire

@@ rtl/robot_remote_command_decoder.sv @@
// Remote command decoder for a legged robot: two-character ASCII commands
// and link ticks go in, one full status snapshot comes out per item.
// Channels: slave stream (s_axis_*) carries items, master stream (m_axis_*)
// carries results, and an APB-style port writes and reads four registers:
// timeout_ticks at 0x0, step_length_init at 0x4, step_period_init at 0x8
// and step_height_init at 0xC. Writing an init register also reloads the
// working gait parameter.
// Each input transfer yields exactly one output transfer holding the state
// after that item. An item passes through the input register, then the
// decode, which updates the state and loads the output register. The
// throughput is one item per cycle while the receiver does not stall, as
// the decode and state update take a new item whenever the output moves.
// At reset both streams are empty, the head sits at 90 degrees, motion is
// static, gait is stand and the link is reported down.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; after that s_axis_tready drops
// until the output is taken.
// Depends on rrcd_pkg, rrcd_cfg, rrcd_state and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module robot_remote_command_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] group_char, [15:8] code_char
  input  wire logic [1:0]  s_axis_tuser,  // [0] kind, [1] source
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] motion_state, [5:4] gait, [13:6] yaw_deg, [21:14] pitch_deg,
  // [29:22] roll_deg, [31:30] head_motion, [37:32] step_length,
  // [44:38] step_period, [49:45] step_height, [50] trot_flag,
  // [51] link_up, [55:52] zero
  output logic [55:0]      m_axis_tdata,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rrcd_pkg::item_t   item_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  rrcd_pkg::result_t out_q;
  rrcd_pkg::result_t result;
  rrcd_pkg::cfg_t    cfg;
  logic              advance;
  logic              in_xfer;

  // Configuration registers.
  rrcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake control: the item in the input register moves on whenever the
  // output register is empty or being emptied in the same cycle.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d  = in_xfer | (in_valid_q & ~advance);
    out_valid_d = advance | (out_valid_q & ~m_axis_tready);
  end

  // Decode and state.
  rrcd_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.kind       <= s_axis_tuser[0];
      item_q.source     <= s_axis_tuser[1];
      item_q.group_char <= s_axis_tdata[7:0];
      item_q.code_char  <= s_axis_tdata[15:8];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};

  // An item that leaves the input register always shows up as a result.
  `RRCD_ASSERT(a_advance_to_out, advance |=> out_valid_q, "decoded item lost before output")
  // Nothing is decoded without an item waiting in the input register.
  `RRCD_ASSERT_NEVER(a_no_phantom_item, advance && !in_valid_q, "decode without input item")

endmodule

`default_nettype wire

@@ dv/tb_robot_remote_command_decoder.sv @@
// Self-checking testbench for the remote command decoder: streams ticks and commands
// through the block, predicts every status snapshot and compares each one field by field.
// Depends on rrcd_pkg and the robot_remote_command_decoder RTL.
`timescale 1ns / 1ps

module tb_robot_remote_command_decoder;
  import rrcd_pkg::*;

  localparam int  IDLE_LIMIT      = 2000;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  ITEMS_PER_PHASE = 355;
  localparam int  SETTLE_CYCLES   = 4;
  localparam int  NUM_FIELDS      = 11;
  localparam logic SRC_AUX        = ~SRC_WIRELESS;

  typedef int field_vec_t [NUM_FIELDS];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] group_char, [15:8] code_char
  logic [1:0]  s_axis_tuser = '0;  // [0] kind, [1] source
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // status snapshot, motion_state in the lowest bits
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  robot_remote_command_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Pending input items, expected snapshots and bookkeeping.
  item_t   item_q [$];
  result_t status_q [$];
  int      errors = 0;
  int      src_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      hold_off_reqs = 0;
  int      hold_off_seen = 0;
  int      hold_off_left = 0;
  int      quiet_cycles = 0;
  logic    in_fire = 1'b0;

  // Settings walked through by the random phases.
  int phase_timeout [5] = '{5, 1, 0, 65535, 8};
  int phase_len [5]     = '{20, 55, 63, 0, 37};
  int phase_per [5]     = '{25, 70, 127, 0, 41};
  int phase_hgt [5]     = '{12, 28, 31, 0, 17};

  string field_name [NUM_FIELDS] = '{"motion_state", "gait", "yaw_deg", "pitch_deg",
                                     "roll_deg", "head_motion", "step_length",
                                     "step_period", "step_height", "trot_flag", "link_up"};

  // Shadow copy of the configuration and of the decoder state.
  logic [15:0] cfg_timeout = TIMEOUT_RST;
  logic [5:0]  cfg_len_init = LEN_RST;
  logic [6:0]  cfg_per_init = PER_RST;
  logic [4:0]  cfg_hgt_init = HGT_RST;
  motion_e     mot_st = MOT_STATIC;
  gait_e       gait_st = GAIT_STAND;
  logic [7:0]  yaw_st = ANGLE_CENTRE;
  logic [7:0]  pitch_st = ANGLE_CENTRE;
  logic [7:0]  roll_st = ANGLE_CENTRE;
  head_e       head_st = HEAD_NONE;
  logic [5:0]  len_st = LEN_RST;
  logic [6:0]  per_st = PER_RST;
  logic [4:0]  hgt_st = HGT_RST;
  logic        trot_st = 1'b0;
  logic [15:0] idle_ticks_st = '0;
  logic        link_st = 1'b0;

  function automatic logic [7:0] angle_up(logic [7:0] a);
    return (int'(a) + int'(ANGLE_STEP) <= int'(ANGLE_MAX)) ? a + ANGLE_STEP : a;
  endfunction

  function automatic logic [7:0] angle_down(logic [7:0] a);
    return (a >= ANGLE_STEP) ? a - ANGLE_STEP : a;
  endfunction

  // Applies one item to the shadow state and returns the snapshot it should produce.
  function automatic result_t decode_item(item_t it);
    result_t snap;
    if (it.kind == KIND_CMD) begin
      case (it.group_char)
        CHAR_0: begin
          case (it.code_char)
            CHAR_5: mot_st = MOT_STEP;
            CHAR_2: mot_st = MOT_FWD;
            CHAR_8: mot_st = MOT_BACK;
            CHAR_4: mot_st = MOT_LEFT;
            CHAR_6: mot_st = MOT_RIGHT;
            CHAR_1: mot_st = MOT_TURN_L;
            CHAR_3: mot_st = MOT_TURN_R;
            CHAR_7: begin
              // The same code means different things depending on the gait.
              if (gait_st == GAIT_TROT) trot_st = 1'b1;
              else if (gait_st == GAIT_TWIST) mot_st = MOT_IMU;
            end
            default: ;
          endcase
        end
        CHAR_1: begin
          trot_st = 1'b0;
          mot_st = MOT_STATIC;
          case (it.code_char)
            CHAR_0:  gait_st = GAIT_WALK;
            CHAR_1:  gait_st = GAIT_TROT;
            CHAR_3:  gait_st = GAIT_TWIST;
            default: gait_st = GAIT_STAND;
          endcase
        end
        CHAR_2: begin
          case (it.code_char)
            CHAR_1: if (int'(len_st) + int'(LEN_STEP) <= int'(LEN_MAX)) len_st = len_st + LEN_STEP;
            CHAR_2: if (len_st >= LEN_MIN_DN) len_st = len_st - LEN_STEP;
            CHAR_3: if (int'(per_st) + 1 <= int'(PER_MAX)) per_st = per_st + 7'd1;
            CHAR_4: if (per_st >= PER_MIN_DN) per_st = per_st - 7'd1;
            CHAR_5: if (int'(hgt_st) + int'(HGT_STEP) <= int'(HGT_MAX)) hgt_st = hgt_st + HGT_STEP;
            CHAR_6: if (hgt_st >= HGT_MIN_DN) hgt_st = hgt_st - HGT_STEP;
            default: ;
          endcase
        end
        CHAR_3: begin
          case (it.code_char)
            CHAR_1: begin yaw_st = angle_up(yaw_st); head_st = HEAD_NONE; end
            CHAR_2: begin yaw_st = angle_down(yaw_st); head_st = HEAD_NONE; end
            CHAR_3: begin pitch_st = angle_up(pitch_st); head_st = HEAD_NONE; end
            CHAR_4: begin pitch_st = angle_down(pitch_st); head_st = HEAD_NONE; end
            CHAR_5: begin roll_st = angle_up(roll_st); head_st = HEAD_NONE; end
            CHAR_6: begin roll_st = angle_down(roll_st); head_st = HEAD_NONE; end
            CHAR_7: head_st = HEAD_NOD;
            CHAR_8: head_st = HEAD_SHAKE;
            CHAR_9: head_st = HEAD_TILT;
            CHAR_0: begin
              head_st = HEAD_NONE;
              yaw_st = ANGLE_CENTRE;
              pitch_st = ANGLE_CENTRE;
              roll_st = ANGLE_CENTRE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      // Wireless commands refresh the link after the decode.
      if (it.source == SRC_WIRELESS) begin
        idle_ticks_st = '0;
        link_st = 1'b1;
      end
    end else begin
      if (idle_ticks_st != 16'hFFFF) idle_ticks_st = idle_ticks_st + 16'd1;
      if (idle_ticks_st >= cfg_timeout) link_st = 1'b0;
    end
    snap.motion_state = mot_st;
    snap.gait         = gait_st;
    snap.yaw_deg      = yaw_st;
    snap.pitch_deg    = pitch_st;
    snap.roll_deg     = roll_st;
    snap.head_motion  = head_st;
    snap.step_length  = len_st;
    snap.step_period  = per_st;
    snap.step_height  = hgt_st;
    snap.trot_flag    = trot_st;
    snap.link_up      = link_st;
    return snap;
  endfunction

  function automatic field_vec_t status_fields(result_t r);
    field_vec_t f;
    f = '{int'(r.motion_state), int'(r.gait), int'(r.yaw_deg), int'(r.pitch_deg),
          int'(r.roll_deg), int'(r.head_motion), int'(r.step_length), int'(r.step_period),
          int'(r.step_height), int'(r.trot_flag), int'(r.link_up)};
    return f;
  endfunction

  // Input side prediction, result checking and the watchdog share one clock edge.
  always @(posedge clk_i) begin : stream_check
    item_t      it;
    result_t    exp_snap;
    field_vec_t exp_f;
    field_vec_t act_f;
    logic       in_ok;
    logic       out_ok;
    in_ok  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_ok = rst_ni && m_axis_tvalid && m_axis_tready;
    in_fire <= in_ok;
    if (in_ok) begin
      it.kind       = s_axis_tuser[0];
      it.source     = s_axis_tuser[1];
      it.group_char = s_axis_tdata[7:0];
      it.code_char  = s_axis_tdata[15:8];
      status_q.push_back(decode_item(it));
    end
    if (out_ok) begin
      if (status_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_snap = status_q.pop_front();
        exp_f = status_fields(exp_snap);
        act_f = status_fields(result_t'(m_axis_tdata[51:0]));
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (exp_f[i] != act_f[i]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[i],
                     exp_f[i], act_f[i]);
            errors++;
          end
        end
      end
    end
    // A run that stops moving is a failure.
    if (in_ok || out_ok) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Item driver: offers the next pending item, with random gaps.
  always @(negedge clk_i) begin : item_driver
    item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.code_char, nxt.group_char};
        s_axis_tuser  <= {nxt.source, nxt.kind};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin : result_sink
    if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic void add_item(logic kind, logic src, logic [7:0] grp, logic [7:0] code);
    item_t it;
    it.kind       = kind;
    it.source     = src;
    it.group_char = grp;
    it.code_char  = code;
    item_q.push_back(it);
  endfunction

  // Mostly well-formed commands, often repeated to run parameters into their limits,
  // mixed with bursts of ticks and byte noise.
  task automatic add_random_items(int n);
    int added;
    int pick;
    int reps;
    logic src;
    logic [7:0] grp;
    logic [7:0] code;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        reps = $urandom_range(1, 12);
        repeat (reps) add_item(KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 32) begin
        reps = 1;
        add_item(KIND_CMD, 1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        src  = ($urandom_range(99) < 75) ? SRC_WIRELESS : SRC_AUX;
        grp  = CHAR_0 + 8'($urandom_range(3));
        code = CHAR_0 + 8'($urandom_range(9));
        reps = ($urandom_range(99) < 70) ? 1 : $urandom_range(2, 40);
        repeat (reps) add_item(KIND_CMD, src, grp, code);
      end
      added += reps;
    end
  endtask

  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(reg_idx_e idx);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b0, idx, '0, rd);
    case (idx)
      REG_TIMEOUT:  want = 32'(cfg_timeout);
      REG_LEN_INIT: want = 32'(cfg_len_init);
      REG_PER_INIT: want = 32'(cfg_per_init);
      default:      want = 32'(cfg_hgt_init);
    endcase
    if (rd !== want) begin
      $display("%0t: register %s read mismatch, expected %0d, actual %0d", $time, idx.name(),
               want, rd);
      errors++;
    end
  endtask

  // Writing an init register also reloads the working parameter.
  task automatic set_reg(reg_idx_e idx, int value);
    logic [31:0] unused;
    apb_access(1'b1, idx, 32'(value), unused);
    case (idx)
      REG_TIMEOUT: cfg_timeout = 16'(value);
      REG_LEN_INIT: begin
        cfg_len_init = 6'(value);
        len_st = cfg_len_init;
      end
      REG_PER_INIT: begin
        cfg_per_init = 7'(value);
        per_st = cfg_per_init;
      end
      default: begin
        cfg_hgt_init = 5'(value);
        hgt_st = cfg_hgt_init;
      end
    endcase
    check_reg(idx);
  endtask

  // Waits until every pending item has been sent and every snapshot has come back.
  task automatic wait_drained();
    while (item_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values of all registers.
    check_reg(REG_TIMEOUT);
    check_reg(REG_LEN_INIT);
    check_reg(REG_PER_INIT);
    check_reg(REG_HGT_INIT);

    // Directed: extreme bytes, every group, gait dependent code 7 and unknown codes.
    add_item(KIND_TICK, SRC_WIRELESS, 8'h00, 8'h00);
    add_item(KIND_TICK, SRC_AUX, 8'hFF, 8'hFF);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_1, CHAR_1);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, CHAR_7);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, CHAR_5);
    add_item(KIND_CMD, SRC_AUX, CHAR_1, CHAR_3);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, CHAR_7);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_1, CHAR_0);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, CHAR_7);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_1, 8'hFF);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, 8'h00);
    add_item(KIND_CMD, SRC_AUX, 8'hFF, 8'hFF);
    add_item(KIND_CMD, SRC_WIRELESS, 8'h00, CHAR_1);
    for (int c = 0; c < 6; c++) add_item(KIND_CMD, SRC_WIRELESS, CHAR_2, CHAR_1 + 8'(c));
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_1);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_4);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_7);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_8);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_9);
    add_item(KIND_CMD, SRC_AUX, CHAR_3, CHAR_0);

    // Random phases, each with its own register settings and one of four idling patterns.
    for (int k = 0; k < 5; k++) begin
      wait_drained();
      set_reg(REG_TIMEOUT, phase_timeout[k]);
      set_reg(REG_LEN_INIT, phase_len[k]);
      set_reg(REG_PER_INIT, phase_per[k]);
      set_reg(REG_HGT_INIT, phase_hgt[k]);
      case (k % 4)
        0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_idle_pct = 58; rx_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rx_stall_pct = 58; end
        default: begin src_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      // In the first phase the receiver holds off so that the block backs up.
      if (k == 0) hold_off_reqs++;
      add_random_items(ITEMS_PER_PHASE);
    end

    // Short tick run against a small timeout, then auxiliary and wireless commands.
    wait_drained();
    src_idle_pct = 0;
    rx_stall_pct = 0;
    set_reg(REG_TIMEOUT, 3);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_3, CHAR_0);
    repeat (4) add_item(KIND_TICK, 1'($urandom), 8'($urandom), 8'($urandom));
    add_item(KIND_CMD, SRC_AUX, CHAR_0, CHAR_2);
    add_item(KIND_CMD, SRC_WIRELESS, CHAR_0, CHAR_2);
    add_item(KIND_TICK, SRC_WIRELESS, 8'h00, 8'h00);

    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
